// ===== hdl/dha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Detector hit aggregator package
// Shared constants and types of the hit aggregator.
// ----------------------------------------------------------------------------
package dha_pkg;

    localparam int MAX_HITS = 16;
    localparam int SUM_W = 36;
    localparam int POS_W = 20;
    localparam int CNT_W = 16;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    typedef struct packed {
        logic [15:0]             track;
        logic [7:0]              det;
        logic [15:0]             kind;
        logic [23:0]             energy;
        logic [23:0]             hit_time;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
    } t_step;

    typedef struct packed {
        logic [15:0]             track;
        logic [7:0]              det;
        logic [15:0]             kind;
        logic [31:0]             energy;
        logic [23:0]             hit_time;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
        logic [CNT_W-1:0]        count;
    } t_entry;

endpackage
`default_nettype wire

// ===== hdl/dha_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hit aggregator channels
// Valid/ready channels for step items and aggregated hit records.
// ----------------------------------------------------------------------------
interface dha_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic               from_primary;
    logic [15:0]        track_id;
    logic [7:0]         det_id;
    logic [15:0]        particle_code;
    logic [23:0]        energy;
    logic [23:0]        hit_time;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    modport source(output valid, func, from_primary, track_id, det_id, particle_code,
                   energy, hit_time, pos_x, pos_y, pos_z, input ready);
    modport sink(input valid, func, from_primary, track_id, det_id, particle_code,
                 energy, hit_time, pos_x, pos_y, pos_z, output ready);
endinterface

interface dha_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        out_track;
    logic [7:0]         out_det;
    logic [15:0]        out_particle;
    logic [31:0]        energy_total;
    logic [23:0]        first_time;
    logic signed [19:0] mean_x;
    logic signed [19:0] mean_y;
    logic signed [19:0] mean_z;
    logic [15:0]        step_total;
    logic               last_record;
    logic               lost_keys;
    modport source(output valid, out_track, out_det, out_particle, energy_total,
                   first_time, mean_x, mean_y, mean_z, step_total, last_record,
                   lost_keys, input ready);
    modport sink(input valid, out_track, out_det, out_particle, energy_total,
                 first_time, mean_x, mean_y, mean_z, step_total, last_record,
                 lost_keys, output ready);
endinterface
`default_nettype wire

// ===== hdl/detector_hit_aggregator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Detector hit aggregator
// Groups primary steps by track and detector in a chain of entry cells.
// A step transaction is captured first, then merged into a cell or allocated.
// The serial divider forms the three mean positions of each emitted record
// one after another.
// An empty event presents its record in the cycle after acceptance.
// Synchronous reset empties the table and clears the lost-key flag.
// ----------------------------------------------------------------------------
module detector_hit_aggregator_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dha_in_if.sink    i_in,
    dha_out_if.source o_out
);
    import dha_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_SEND = 5'b10000
    } t_state;

    t_state r_state;
    t_step  r_step;
    t_entry r_head;
    logic   r_last;
    logic   r_over;
    logic [1:0] r_axis;
    logic [POS_W-1:0] r_mx;
    logic [POS_W-1:0] r_my;
    logic [POS_W-1:0] r_mz;
    logic   r_empty;
    logic   r_start;

    t_entry w_entry [0:MAX_HITS];
    logic   w_valid [0:MAX_HITS];
    logic [MAX_HITS-1:0] w_match;
    logic   w_any;
    logic   w_accept;
    logic   w_done;
    logic [POS_W-1:0] w_quot;
    logic signed [SUM_W-1:0] w_dividend;

    assign w_entry[MAX_HITS] = '0;
    assign w_valid[MAX_HITS] = 1'b0;
    assign w_any = |w_match;

    genvar g;
    generate
        for (g = 0; g < MAX_HITS; g++) begin : g_cell
            dha_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_step      (r_step),
                .i_step_en   (r_state == S_STEP),
                .i_any_match (w_any),
                .i_prev_valid((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g - 1]),
                .i_shift     (r_state == S_LOAD),
                .i_next      (w_entry[g + 1]),
                .i_next_valid(w_valid[g + 1]),
                .o_entry     (w_entry[g]),
                .o_valid     (w_valid[g]),
                .o_match     (w_match[g])
            );
        end
    endgenerate

    always_comb begin
        unique case (r_axis)
            2'd0:    w_dividend = r_head.sx;
            2'd1:    w_dividend = r_head.sy;
            default: w_dividend = r_head.sz;
        endcase
    end

    dha_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_dividend(w_dividend),
        .i_divisor (r_head.count),
        .o_done    (w_done),
        .o_quot    (w_quot)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_step.track    <= i_in.track_id;
            r_step.det      <= i_in.det_id;
            r_step.kind     <= i_in.particle_code;
            r_step.energy   <= i_in.energy;
            r_step.hit_time <= i_in.hit_time;
            r_step.px       <= i_in.pos_x;
            r_step.py       <= i_in.pos_y;
            r_step.pz       <= i_in.pos_z;
        end
        if (r_state == S_LOAD) begin
            r_head <= w_entry[0];
            r_last <= !w_valid[1];
        end
        if (w_done) begin
            unique case (r_axis)
                2'd0:    r_mx <= w_quot;
                2'd1:    r_my <= w_quot;
                default: r_mz <= w_quot;
            endcase
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_over  <= 1'b0;
            r_axis  <= '0;
            r_start <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in.func) begin
                            if (w_valid[0]) begin
                                r_empty <= 1'b0;
                                r_state <= S_LOAD;
                            end else begin
                                r_empty <= 1'b1;
                                r_state <= S_SEND;
                            end
                        end else if (i_in.from_primary) begin
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    if (!w_any && w_valid[MAX_HITS-1]) begin
                        r_over <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_LOAD: begin
                    r_axis  <= 2'd0;
                    r_start <= 1'b1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_done) begin
                        if (r_axis == 2'd2) begin
                            r_state <= S_SEND;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_start <= 1'b1;
                        end
                    end
                end
                S_SEND: begin
                    if (o_out.ready) begin
                        if (r_empty || r_last) begin
                            r_over  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = (r_state == S_SEND);
    assign o_out.out_track    = r_empty ? '0 : r_head.track;
    assign o_out.out_det      = r_empty ? '0 : r_head.det;
    assign o_out.out_particle = r_empty ? '0 : r_head.kind;
    assign o_out.energy_total = r_empty ? '0 : r_head.energy;
    assign o_out.first_time   = r_empty ? '0 : r_head.hit_time;
    assign o_out.mean_x       = r_empty ? '0 : r_mx;
    assign o_out.mean_y       = r_empty ? '0 : r_my;
    assign o_out.mean_z       = r_empty ? '0 : r_mz;
    assign o_out.step_total   = r_empty ? '0 : r_head.count;
    assign o_out.last_record  = r_empty || r_last;
    assign o_out.lost_keys    = r_over;
endmodule
`default_nettype wire

// ===== hdl/dha_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hit aggregator cell
// Holds one table entry, merges matching steps, takes a new key when it is the
// first free cell and no cell matches, and shifts toward the head.
module dha_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dha_pkg::t_step i_step,
    input  wire logic           i_step_en,
    input  wire logic           i_any_match,
    input  wire logic           i_prev_valid,
    input  wire logic           i_shift,
    input  wire dha_pkg::t_entry i_next,
    input  wire logic           i_next_valid,
    output dha_pkg::t_entry     o_entry,
    output logic                o_valid,
    output logic                o_match
);
    import dha_pkg::*;

    t_entry      r_entry;
    t_entry      n_entry;
    logic        r_valid;
    logic        n_valid;
    logic [32:0] w_esum;

    assign o_match = r_valid && (r_entry.track == i_step.track) && (r_entry.det == i_step.det);
    assign w_esum  = {1'b0, r_entry.energy} + {9'd0, i_step.energy};

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_shift) begin
            n_entry = i_next;
            n_valid = i_next_valid;
        end else if (i_step_en && o_match) begin
            n_entry.energy = w_esum[32] ? 32'hFFFF_FFFF : w_esum[31:0];
            if (i_step.hit_time < r_entry.hit_time) begin
                n_entry.hit_time = i_step.hit_time;
            end
            if (r_entry.count != {CNT_W{1'b1}}) begin
                n_entry.count = r_entry.count + 1'b1;
                n_entry.sx = r_entry.sx + SUM_W'(i_step.px);
                n_entry.sy = r_entry.sy + SUM_W'(i_step.py);
                n_entry.sz = r_entry.sz + SUM_W'(i_step.pz);
            end
        end else if (i_step_en && !i_any_match && i_prev_valid && !r_valid) begin
            n_valid = 1'b1;
            n_entry.track = i_step.track;
            n_entry.det = i_step.det;
            n_entry.kind = i_step.kind;
            n_entry.energy = {8'd0, i_step.energy};
            n_entry.hit_time = i_step.hit_time;
            n_entry.sx = SUM_W'(i_step.px);
            n_entry.sy = SUM_W'(i_step.py);
            n_entry.sz = SUM_W'(i_step.pz);
            n_entry.count = CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
endmodule
`default_nettype wire

// ===== hdl/dha_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hit aggregator divider
// Serial restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module dha_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic signed [dha_pkg::SUM_W-1:0] i_dividend,
    input  wire logic [dha_pkg::CNT_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [dha_pkg::POS_W-1:0]       o_quot
);
    import dha_pkg::*;

    logic [SUM_W-1:0]     r_quot;
    logic [CNT_W:0]       r_rem;
    logic [CNT_W-1:0]     r_div;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W:0]       w_rem_sh;
    logic [CNT_W+1:0]     w_diff;
    logic [SUM_W-1:0]     w_signed;

    assign w_rem_sh = {r_rem[CNT_W-1:0], r_quot[SUM_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_div};
    assign w_signed = r_neg ? (~r_quot + 1'b1) : r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_dividend[SUM_W-1];
            r_quot <= i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[CNT_W+1]) begin
                r_rem  <= w_diff[CNT_W:0];
                r_quot <= {r_quot[SUM_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_quot <= {r_quot[SUM_W-2:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = w_signed[POS_W-1:0];
endmodule
`default_nettype wire

// ===== sim/detector_hit_aggregator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector hit aggregator test
// Drives step and end-of-event transactions with random gaps and stalls,
// predicts the aggregated hit records and checks each one as it arrives.
// ----------------------------------------------------------------------------
module detector_hit_aggregator_top_test;
    import dha_pkg::*;

    localparam int FUNC_STEP = 0;
    localparam int FUNC_EOE = 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic        func;
        logic        prim;
        logic [15:0] trk;
        logic [7:0]  det;
        logic [15:0] kind;
        logic [23:0] en;
        logic [23:0] tm;
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic signed [19:0] pz;
    } t_step_item;

    typedef struct packed {
        logic [15:0] trk;
        logic [7:0]  det;
        logic [15:0] kind;
        logic [31:0] energy;
        logic [23:0] first_time;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic signed [19:0] mz;
        logic [15:0] steps;
        logic        last;
        logic        lost;
    } t_hit_record;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dha_in_if  step_ch ();
    dha_out_if hit_ch ();

    detector_hit_aggregator_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (step_ch.sink),
        .o_out  (hit_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_step_item  pending_steps[$];
    t_hit_record expected_hits[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          idle_free = 1'b0;
    bit          rx_hold = 1'b0;
    bit          in_fire = 1'b0;

    // Table model.
    int                used_entries;
    bit                table_overflow;
    logic [15:0]       tbl_trk[MAX_HITS];
    logic [7:0]        tbl_det[MAX_HITS];
    logic [15:0]       tbl_kind[MAX_HITS];
    logic [31:0]       tbl_energy[MAX_HITS];
    logic [23:0]       tbl_time[MAX_HITS];
    longint            tbl_sx[MAX_HITS];
    longint            tbl_sy[MAX_HITS];
    longint            tbl_sz[MAX_HITS];
    int unsigned       tbl_count[MAX_HITS];

    function automatic logic [19:0] mean_of(longint sum, int unsigned cnt);
        longint m;
        m = (cnt != 0) ? sum / longint'(cnt) : 0;
        return m[19:0];
    endfunction

    task automatic aggregate_step(input t_step_item s);
        t_hit_record r;
        longint      e;
        bit          found;
        found = 1'b0;
        if (s.func == FUNC_EOE) begin
            if (used_entries == 0) begin
                r = '0;
                r.last = 1'b1;
                r.lost = table_overflow;
                expected_hits.push_back(r);
            end else begin
                for (int i = 0; i < used_entries; i++) begin
                    r.trk = tbl_trk[i];
                    r.det = tbl_det[i];
                    r.kind = tbl_kind[i];
                    r.energy = tbl_energy[i];
                    r.first_time = tbl_time[i];
                    r.mx = mean_of(tbl_sx[i], tbl_count[i]);
                    r.my = mean_of(tbl_sy[i], tbl_count[i]);
                    r.mz = mean_of(tbl_sz[i], tbl_count[i]);
                    r.steps = tbl_count[i][15:0];
                    r.last = (i == used_entries - 1);
                    r.lost = table_overflow;
                    expected_hits.push_back(r);
                end
            end
            used_entries = 0;
            table_overflow = 1'b0;
            return;
        end
        if (!s.prim) return;
        for (int i = 0; i < used_entries; i++) begin
            if (!found && tbl_trk[i] == s.trk && tbl_det[i] == s.det) begin
                found = 1'b1;
                e = longint'(tbl_energy[i]) + longint'(s.en);
                tbl_energy[i] = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
                if (s.tm < tbl_time[i]) tbl_time[i] = s.tm;
                if (tbl_count[i] < 65535) begin
                    tbl_count[i]++;
                    tbl_sx[i] += longint'(s.px);
                    tbl_sy[i] += longint'(s.py);
                    tbl_sz[i] += longint'(s.pz);
                end
            end
        end
        if (found) return;
        if (used_entries >= MAX_HITS) begin
            table_overflow = 1'b1;
            return;
        end
        tbl_trk[used_entries] = s.trk;
        tbl_det[used_entries] = s.det;
        tbl_kind[used_entries] = s.kind;
        tbl_energy[used_entries] = {8'd0, s.en};
        tbl_time[used_entries] = s.tm;
        tbl_sx[used_entries] = longint'(s.px);
        tbl_sy[used_entries] = longint'(s.py);
        tbl_sz[used_entries] = longint'(s.pz);
        tbl_count[used_entries] = 1;
        used_entries++;
    endtask

    function automatic t_step_item random_step(input logic [15:0] trk, input logic [7:0] det);
        t_step_item s;
        s.func = 1'(FUNC_STEP);
        s.prim = ($urandom_range(0, 9) != 0);
        s.trk = trk;
        s.det = det;
        s.kind = 16'($urandom);
        s.en = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom);
        s.tm = 24'($urandom);
        s.px = 20'($urandom);
        s.py = 20'($urandom);
        s.pz = 20'($urandom);
        return s;
    endfunction

    function automatic t_step_item end_of_event();
        t_step_item s;
        s = random_step(16'($urandom), 8'($urandom));
        s.func = 1'(FUNC_EOE);
        s.prim = 1'($urandom);
        return s;
    endfunction

    // Driver: one transaction per handshake, changes on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            step_ch.valid <= 1'b0;
            {step_ch.func, step_ch.from_primary, step_ch.track_id, step_ch.det_id,
             step_ch.particle_code, step_ch.energy, step_ch.hit_time,
             step_ch.pos_x, step_ch.pos_y, step_ch.pos_z} <= '0;
        end else if (!step_ch.valid || in_fire) begin
            if (pending_steps.size() != 0 && (idle_free || $urandom_range(0, 99) >= 37)) begin
                step_ch.valid <= 1'b1;
                {step_ch.func, step_ch.from_primary, step_ch.track_id, step_ch.det_id,
                 step_ch.particle_code, step_ch.energy, step_ch.hit_time,
                 step_ch.pos_x, step_ch.pos_y, step_ch.pos_z} <= pending_steps.pop_front();
            end else begin
                step_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        hit_ch.ready <= !rx_hold && (idle_free || $urandom_range(0, 99) >= 37);
    end

    // Predict on acceptance at the rising edge.
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && step_ch.valid && step_ch.ready;
        if (i_rst_n && step_ch.valid && step_ch.ready) begin
            aggregate_step({step_ch.func, step_ch.from_primary, step_ch.track_id,
                            step_ch.det_id, step_ch.particle_code, step_ch.energy,
                            step_ch.hit_time, step_ch.pos_x, step_ch.pos_y, step_ch.pos_z});
        end
    end

    // Monitor: compare each accepted record with the oldest prediction.
    always @(posedge i_clk) begin
        t_hit_record x;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && hit_ch.valid && hit_ch.ready) begin
            if (expected_hits.size() == 0) begin
                $error("unexpected record track=%0h det=%0h", hit_ch.out_track, hit_ch.out_det);
                fail_count++;
            end else begin
                x = expected_hits.pop_front();
                if (hit_ch.out_track !== x.trk) begin
                    $error("out_track exp %0h got %0h", x.trk, hit_ch.out_track); fail_count++;
                end
                if (hit_ch.out_det !== x.det) begin
                    $error("out_det exp %0h got %0h", x.det, hit_ch.out_det); fail_count++;
                end
                if (hit_ch.out_particle !== x.kind) begin
                    $error("out_particle exp %0h got %0h", x.kind, hit_ch.out_particle);
                    fail_count++;
                end
                if (hit_ch.energy_total !== x.energy) begin
                    $error("energy_total exp %0h got %0h", x.energy, hit_ch.energy_total);
                    fail_count++;
                end
                if (hit_ch.first_time !== x.first_time) begin
                    $error("first_time exp %0h got %0h", x.first_time, hit_ch.first_time);
                    fail_count++;
                end
                if (hit_ch.mean_x !== x.mx) begin
                    $error("mean_x exp %0d got %0d", x.mx, hit_ch.mean_x); fail_count++;
                end
                if (hit_ch.mean_y !== x.my) begin
                    $error("mean_y exp %0d got %0d", x.my, hit_ch.mean_y); fail_count++;
                end
                if (hit_ch.mean_z !== x.mz) begin
                    $error("mean_z exp %0d got %0d", x.mz, hit_ch.mean_z); fail_count++;
                end
                if (hit_ch.step_total !== x.steps) begin
                    $error("step_total exp %0d got %0d", x.steps, hit_ch.step_total);
                    fail_count++;
                end
                if (hit_ch.last_record !== x.last) begin
                    $error("last_record exp %0b got %0b", x.last, hit_ch.last_record);
                    fail_count++;
                end
                if (hit_ch.lost_keys !== x.lost) begin
                    $error("lost_keys exp %0b got %0b", x.lost, hit_ch.lost_keys);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver hold-off: counted in cycles while the sender keeps offering.
    initial begin
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (2000) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic wait_drained();
        while (pending_steps.size() != 0 || step_ch.valid || expected_hits.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_step_item s;
        int         n_keys;
        int         n_steps;
        used_entries = 0;
        table_overflow = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty event, extremes, ties, secondaries, overflow.
        pending_steps.push_back(end_of_event());
        s = random_step(16'hFFFF, 8'hFF);
        s.prim = 1'b1; s.en = 24'hFFFFFF; s.tm = 24'hFFFFFF;
        s.px = 20'sh7FFFF; s.py = 20'sh80000; s.pz = -20'sd1;
        pending_steps.push_back(s);
        s.px = 20'sh7FFFF; s.py = 20'sh80000; s.pz = 20'sd0;
        pending_steps.push_back(s);
        s.tm = 24'hFFFFFF;
        pending_steps.push_back(s);
        s.tm = 24'd0; s.px = -20'sd3; s.kind = 16'h0000;
        pending_steps.push_back(s);
        s = random_step(16'd0, 8'd0);
        s.prim = 1'b0;
        pending_steps.push_back(s);
        s.prim = 1'b1; s.en = 24'd0; s.tm = 24'd0; s.px = '0; s.py = '0; s.pz = '0;
        pending_steps.push_back(s);
        pending_steps.push_back(end_of_event());
        for (int k = 0; k < MAX_HITS + 2; k++) begin
            s = random_step(k[15:0], 8'd7);
            s.prim = 1'b1;
            pending_steps.push_back(s);
        end
        pending_steps.push_back(end_of_event());
        pending_steps.push_back(end_of_event());

        // Sender pause until every record has come.
        wait_drained();

        // Random events from a small key pool so keys repeat.
        while (pending_steps.size() < 300 && cycle_count < 40000) begin
            n_keys = $urandom_range(1, 20);
            n_steps = $urandom_range(0, 30);
            for (int k = 0; k < n_steps; k++) begin
                s = random_step(16'($urandom_range(0, n_keys - 1)), 8'($urandom_range(0, 2)));
                if ($urandom_range(0, 19) == 0) s = random_step(16'($urandom), 8'($urandom));
                pending_steps.push_back(s);
            end
            pending_steps.push_back(end_of_event());
        end
        idle_free = 1'b1;
        for (int ev = 0; ev < 6; ev++) begin
            for (int k = 0; k < 10; k++) begin
                pending_steps.push_back(random_step(16'($urandom_range(0, 4)), 8'd1));
            end
            pending_steps.push_back(end_of_event());
        end
        wait_drained();
        idle_free = 1'b0;
        for (int ev = 0; ev < 10; ev++) begin
            for (int k = 0; k < 12; k++) begin
                pending_steps.push_back(random_step(16'($urandom_range(0, 6)), 8'd3));
            end
            pending_steps.push_back(end_of_event());
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_hits.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dha_pkg.sv
hdl/dha_if.sv
hdl/dha_cell.sv
hdl/dha_div.sv
hdl/detector_hit_aggregator_top.sv
sim/detector_hit_aggregator_top_test.sv
